// ----- rtl/lfgf_pkg.sv -----
// ----------------------------------------------------------------------------
// lfgf_pkg
// Shared types and constants for the lowest free gap finder.
// ----------------------------------------------------------------------------
package lfgf_pkg;

    // stream widths, padded to whole bytes
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;
    localparam int GAP_W       = 64;
    localparam int REG_W       = 48;

    // configuration register indexes
    localparam logic CFG_REQUEST_SIZE = 1'b0;
    localparam logic CFG_MIN_ADDRESS  = 1'b1;

    // characters with a meaning to the parser
    localparam logic [7:0] CHAR_DASH    = 8'h2d;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    // parse phases
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_END   = 2'd1;
    localparam logic [1:0] PH_SKIP  = 2'd2;

    // reset values of the configuration registers
    localparam logic [REG_W-1:0] REQUEST_SIZE_RST = 48'd4096;
    localparam logic [REG_W-1:0] MIN_ADDRESS_RST  = 48'h10000;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] digit;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.is_hex = 1'b1;
        h.digit  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.digit = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.digit = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.digit = 4'(c - 8'h37);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

// ----- rtl/lowest_free_gap_finder_unit.sv -----
// ----------------------------------------------------------------------------
// lowest_free_gap_finder_unit
// Parses a text listing of sorted regions and returns the first-fit gap.
// ----------------------------------------------------------------------------
// Takes one character of a "hexstart-hexend ..." region listing per clock and
// keeps a running candidate address that starts at min_address. Each finished
// region freezes the candidate when the space below the region holds the
// page-rounded request size, else lifts it to the page-rounded end if higher.
// The character marked tlast produces one result request in the next cycle: the
// candidate and a found flag, or zero when request_size is zero. Every
// character is handled by the combinational decode and region-check logic in
// front of the state registers; no clearing pass after reset. The result sits in
// an output register; s_tready drops only while it holds a result not yet taken.
// The user writes configuration between listings; the block does not check it.
module lowest_free_gap_finder_unit #(
    parameter int PAGE_BITS = 12,
    parameter int ADDR_BITS = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic                               cfg_index,
    input  logic [lfgf_pkg::REG_W-1:0]         cfg_wdata,
    // character stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [lfgf_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] text_char
    input  logic                               s_tlast,   // last_char
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [lfgf_pkg::OUT_TDATA_W-1:0]   m_tdata    // [63:0] gap_address,
                                                          // [64] gap_found, rest 0
);

    localparam logic [ADDR_BITS-1:0] PAGE_MASK =
        ADDR_BITS'((64'd1 << PAGE_BITS) - 64'd1);

    // configuration state
    logic [ADDR_BITS-1:0]      need_reg;
    logic                      req_zero_reg;
    logic [lfgf_pkg::REG_W-1:0] min_addr_reg;
    logic [63:0]               cfg_ext;
    logic [ADDR_BITS-1:0]      cfg_trunc;

    // parser state
    logic [1:0]           phase_reg,  phase_next;
    logic [ADDR_BITS-1:0] acc_reg,    acc_next;
    logic [ADDR_BITS-1:0] start_reg,  start_next;
    logic [ADDR_BITS-1:0] cand_reg,   cand_next;
    logic                 done_reg,   done_next;
    logic                 fresh_reg,  fresh_next;

    // result register
    logic                      m_valid_reg;
    logic [lfgf_pkg::GAP_W-1:0] gap_reg,   gap_next;
    logic                      found_reg, found_next;

    logic                 accept;
    lfgf_pkg::hex_t       hx;
    logic [ADDR_BITS-1:0] acc_shift;
    logic [ADDR_BITS-1:0] cand_eff;
    logic [ADDR_BITS-1:0] check_start;
    logic [ADDR_BITS-1:0] check_end;
    logic                 do_check;
    logic                 dash_last;
    logic                 is_nl;
    logic                 fits;
    logic [ADDR_BITS-1:0] cand_chk;
    logic [63:0]          min_ext;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign cfg_ext   = {16'b0, cfg_wdata};
    assign cfg_trunc = cfg_ext[ADDR_BITS-1:0];
    assign min_ext   = {16'b0, min_addr_reg};

    assign hx        = lfgf_pkg::hex_decode(s_tdata);
    assign is_nl     = (s_tdata == lfgf_pkg::CHAR_NEWLINE);
    assign acc_shift = {acc_reg[ADDR_BITS-5:0], hx.digit};
    assign cand_eff  = fresh_reg ? min_ext[ADDR_BITS-1:0] : cand_reg;

    // a dash on the last character opens a region with an empty end number
    assign dash_last = (phase_reg == lfgf_pkg::PH_START) && s_tlast &&
                       (s_tdata == lfgf_pkg::CHAR_DASH);

    // a region ends on a non-hex character, or on the last character mid-number
    assign do_check  = !done_reg &&
                       (((phase_reg == lfgf_pkg::PH_END) && (!hx.is_hex || s_tlast)) ||
                        dash_last);
    assign check_start = dash_last ? acc_reg : start_reg;
    assign check_end   = dash_last ? '0 : (hx.is_hex ? acc_shift : acc_reg);

    lfgf_region_check #(
        .PAGE_BITS (PAGE_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_check (
        .region_start   (check_start),
        .region_end     (check_end),
        .candidate      (cand_eff),
        .need           (need_reg),
        .fits           (fits),
        .candidate_next (cand_chk)
    );

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        start_next = start_reg;
        cand_next  = cand_eff;
        done_next  = done_reg;
        fresh_next = 1'b0;
        if (!done_reg) begin
            case (phase_reg)
                lfgf_pkg::PH_START: begin
                    if (hx.is_hex) begin
                        acc_next = acc_shift;
                    end else if (s_tdata == lfgf_pkg::CHAR_DASH) begin
                        start_next = acc_reg;
                        acc_next   = '0;
                        phase_next = lfgf_pkg::PH_END;
                    end else begin
                        acc_next   = '0;
                        phase_next = is_nl ? lfgf_pkg::PH_START : lfgf_pkg::PH_SKIP;
                    end
                end
                lfgf_pkg::PH_END: begin
                    if (hx.is_hex) begin
                        acc_next = acc_shift;
                    end else begin
                        acc_next   = '0;
                        phase_next = is_nl ? lfgf_pkg::PH_START : lfgf_pkg::PH_SKIP;
                    end
                end
                default: begin
                    if (is_nl) begin
                        acc_next   = '0;
                        phase_next = lfgf_pkg::PH_START;
                    end
                end
            endcase
        end
        if (do_check) begin
            done_next = fits;
            cand_next = cand_chk;
        end

        gap_next   = req_zero_reg ? '0 : lfgf_pkg::GAP_W'(cand_next);
        found_next = !req_zero_reg && done_next;

        // get ready for the next listing
        if (s_tlast) begin
            phase_next = lfgf_pkg::PH_START;
            acc_next   = '0;
            start_next = '0;
            done_next  = 1'b0;
            fresh_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            need_reg     <= (ADDR_BITS'(lfgf_pkg::REQUEST_SIZE_RST) + PAGE_MASK) & ~PAGE_MASK;
            req_zero_reg <= 1'b0;
            min_addr_reg <= lfgf_pkg::MIN_ADDRESS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lfgf_pkg::CFG_REQUEST_SIZE: begin
                    need_reg     <= (cfg_trunc + PAGE_MASK) & ~PAGE_MASK;
                    req_zero_reg <= (cfg_wdata == '0);
                end
                lfgf_pkg::CFG_MIN_ADDRESS: begin
                    min_addr_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lfgf_pkg::PH_START;
            acc_reg   <= '0;
            start_reg <= '0;
            done_reg  <= 1'b0;
            fresh_reg <= 1'b1;
        end else if (accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            start_reg <= start_next;
            done_reg  <= done_next;
            fresh_reg <= fresh_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cand_reg <= cand_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= s_tlast;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            gap_reg   <= gap_next;
            found_reg <= found_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, found_reg, gap_reg};

endmodule

// ----- rtl/lfgf_region_check.sv -----
// ----------------------------------------------------------------------------
// lfgf_region_check
// First-fit test of one region against the running candidate address.
// ----------------------------------------------------------------------------
module lfgf_region_check #(
    parameter int PAGE_BITS = 12,
    parameter int ADDR_BITS = 64
) (
    input  logic [ADDR_BITS-1:0] region_start,
    input  logic [ADDR_BITS-1:0] region_end,
    input  logic [ADDR_BITS-1:0] candidate,
    input  logic [ADDR_BITS-1:0] need,
    output logic                 fits,
    output logic [ADDR_BITS-1:0] candidate_next
);

    localparam logic [ADDR_BITS-1:0] PAGE_MASK =
        ADDR_BITS'((64'd1 << PAGE_BITS) - 64'd1);

    logic [ADDR_BITS-1:0] gap;
    logic [ADDR_BITS-1:0] end_rounded;

    assign gap         = region_start - candidate;
    assign end_rounded = (region_end + PAGE_MASK) & ~PAGE_MASK;
    assign fits        = (region_start > candidate) && (gap >= need);

    always_comb begin
        candidate_next = candidate;
        if (!fits && region_end > candidate) begin
            candidate_next = end_rounded;
        end
    end

endmodule

// ----- rtl/lfgf_checker.sv -----
// ----------------------------------------------------------------------------
// lfgf_checker
// Port-level checks for the lowest free gap finder, bound to the top level.
// ----------------------------------------------------------------------------
module lfgf_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [lfgf_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result request holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // the last character always yields a result
    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last character");

    // other characters never yield one
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> !m_tvalid)
        else $error("result without last character");

    // input is only held off while a result waits
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with free output");

    // padding bits stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[lfgf_pkg::OUT_TDATA_W-1:lfgf_pkg::GAP_W+1] == '0)
        else $error("nonzero padding in result");

endmodule

bind lowest_free_gap_finder_unit lfgf_checker u_lfgf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
